>>> rtl/core/perfect_triple_matching_search_assert.svh
// ----------------------------------------------------------------------------
// perfect_triple_matching_search assertion macros
// shared concurrent assertion forms for the search block
// ----------------------------------------------------------------------------
`ifndef PERFECT_TRIPLE_MATCHING_SEARCH_ASSERT_SVH
`define PERFECT_TRIPLE_MATCHING_SEARCH_ASSERT_SVH

// same-cycle implication
`define PTMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptms assertion failed");

// next-cycle implication
`define PTMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptms assertion failed");

`endif

>>> rtl/core/ptms_pkg.sv
// ----------------------------------------------------------------------------
// ptms_pkg
// types and constants shared by the matching search block
// ----------------------------------------------------------------------------
`default_nettype none

package ptms_pkg;

    localparam int STORE_AW    = 9;
    localparam int STORE_DEPTH = 512;
    localparam int CFG_W       = 4;
    localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

    typedef logic [STORE_AW-1:0] t_addr;

    // cube store read request from the walker
    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_rd_req;

    // walker status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic is_strong;
    } t_walk_sts;

endpackage

`default_nettype wire

>>> rtl/core/ptms_ram.sv
// ----------------------------------------------------------------------------
// ptms_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ptms_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ptms_walker.sv
// ----------------------------------------------------------------------------
// ptms_walker
// backtracking search for a non-identity all-true row matching
// ----------------------------------------------------------------------------
`default_nettype none

module ptms_walker #(
    parameter int MAX_SIZE = 8
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_start,
    input  wire logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] i_size_m1,
    output ptms_pkg::t_rd_req                                o_rd,
    input  wire logic                                        i_rd_data,
    output ptms_pkg::t_walk_sts                              o_sts
);

    import ptms_pkg::*;

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ADV   = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [IW-1:0]       r_row, n_row;
    logic [IW-1:0]       r_cj, n_cj;
    logic [IW-1:0]       r_ck, n_ck;
    logic [MAX_SIZE-1:0] r_used_b, n_used_b;
    logic [MAX_SIZE-1:0] r_used_c, n_used_c;
    logic [IW-1:0]       r_sel_j [MAX_SIZE];
    logic [IW-1:0]       r_sel_k [MAX_SIZE];
    logic [IW-1:0]       n_sel_j [MAX_SIZE];
    logic [IW-1:0]       n_sel_k [MAX_SIZE];
    t_addr               r_row_base, n_row_base;
    t_addr               r_ss, n_ss;
    logic                r_done, n_done;
    logic                r_strong, n_strong;

    t_addr               s_w;
    t_addr               col_off;
    logic [IW-1:0]       row_prev;
    logic                id_prefix;

    assign s_w      = t_addr'(i_size_m1) + t_addr'(1);
    assign col_off  = t_addr'(t_addr'(r_cj) * s_w);
    assign row_prev = r_row - 1'b1;

    // set when the rows above the current one all sit on the diagonal
    always_comb begin
        id_prefix = 1'b1;
        for (int i = 0; i < MAX_SIZE; i++) begin
            if (IW'(i) < r_row) begin
                if ((r_sel_j[i] != IW'(i)) || (r_sel_k[i] != IW'(i))) begin
                    id_prefix = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_cj       = r_cj;
        n_ck       = r_ck;
        n_used_b   = r_used_b;
        n_used_c   = r_used_c;
        n_sel_j    = r_sel_j;
        n_sel_k    = r_sel_k;
        n_row_base = r_row_base;
        n_ss       = r_ss;
        n_done     = 1'b0;
        n_strong   = r_strong;
        o_rd.en    = 1'b0;
        o_rd.addr  = r_row_base + col_off + t_addr'(r_ck);

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_row      = '0;
                    n_cj       = '0;
                    n_ck       = '0;
                    n_used_b   = '0;
                    n_used_c   = '0;
                    n_row_base = '0;
                    n_ss       = t_addr'(s_w * s_w);
                    n_state    = ST_PROBE;
                end
            end
            ST_ADV: begin
                if (r_ck != i_size_m1) begin
                    n_ck    = r_ck + 1'b1;
                    n_state = ST_PROBE;
                end else if (r_cj != i_size_m1) begin
                    n_ck    = '0;
                    n_cj    = r_cj + 1'b1;
                    n_state = ST_PROBE;
                end else if (r_row == '0) begin
                    // every branch exhausted
                    n_done   = 1'b1;
                    n_strong = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    // pop one row and resume after its choice
                    n_row                      = row_prev;
                    n_cj                       = r_sel_j[row_prev];
                    n_ck                       = r_sel_k[row_prev];
                    n_used_b[r_sel_j[row_prev]] = 1'b0;
                    n_used_c[r_sel_k[row_prev]] = 1'b0;
                    n_row_base                 = r_row_base - r_ss;
                end
            end
            ST_PROBE: begin
                if (r_used_b[r_cj] || r_used_c[r_ck]) begin
                    n_state = ST_ADV;
                end else begin
                    o_rd.en = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_rd_data) begin
                    n_state = ST_ADV;
                end else if (r_row == i_size_m1) begin
                    if (id_prefix && (r_cj == r_row) && (r_ck == r_row)) begin
                        // the all-identity pair does not count
                        n_state = ST_ADV;
                    end else begin
                        n_done   = 1'b1;
                        n_strong = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_sel_j[r_row] = r_cj;
                    n_sel_k[r_row] = r_ck;
                    n_used_b[r_cj] = 1'b1;
                    n_used_c[r_ck] = 1'b1;
                    n_row          = r_row + 1'b1;
                    n_cj           = '0;
                    n_ck           = '0;
                    n_row_base     = r_row_base + r_ss;
                    n_state        = ST_PROBE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_row      <= n_row;
        r_cj       <= n_cj;
        r_ck       <= n_ck;
        r_used_b   <= n_used_b;
        r_used_c   <= n_used_c;
        r_sel_j    <= n_sel_j;
        r_sel_k    <= n_sel_k;
        r_row_base <= n_row_base;
        r_ss       <= n_ss;
        r_strong   <= n_strong;
    end

    assign o_sts.busy      = (r_state != ST_IDLE);
    assign o_sts.done      = r_done;
    assign o_sts.is_strong = r_strong;

endmodule

`default_nettype wire

>>> rtl/core/perfect_triple_matching_search.sv
// ----------------------------------------------------------------------------
// perfect_triple_matching_search
// loads a boolean cube bit by bit, then searches for a non-identity
// permutation pair that hits only true entries
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// input     in         start high, busy low        i_cube_bit, i_last_bit
// result    out        o_done strobe, one cycle    o_is_strong
// config    in         i_cfg_valid & o_cfg_ready   i_cfg_data (size in use)
//
// loading takes one cube bit per cycle, busy stays low while loading
// the transaction with the last bit starts a depth-first walk over rows;
// each candidate (column, slice) of a row is probed, read through the
// single cube store read port if both are free, then checked and advanced
// the result strobe is registered with the return to idle, busy is low then
// reset is synchronous, active low; the result side cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module perfect_triple_matching_search #(
    parameter int MAX_SIZE = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_cube_bit,
    input  wire logic                        i_last_bit,
    output logic                             o_done,
    output logic                             o_is_strong,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ptms_pkg::CFG_W-1:0]  i_cfg_data
);

    import ptms_pkg::*;

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [CFG_W-1:0] r_size;
    t_addr            r_load_count;
    logic [CFG_W-1:0] size_clamp;
    logic [IW-1:0]    size_m1;
    logic             accept;
    logic             rd_data;
    t_rd_req          rd;
    t_walk_sts        sts;

    assign accept      = start && !busy;
    assign busy        = sts.busy;
    assign o_cfg_ready = !sts.busy;
    assign o_done      = sts.done;
    assign o_is_strong = sts.is_strong;

    always_comb begin
        if (r_size == '0) begin
            size_clamp = CFG_W'(1);
        end else if (r_size > CFG_W'(MAX_SIZE)) begin
            size_clamp = CFG_W'(MAX_SIZE);
        end else begin
            size_clamp = r_size;
        end
    end

    assign size_m1 = IW'(size_clamp - CFG_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size       <= SIZE_RESET;
            r_load_count <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
            if (accept) begin
                // address wraps, a search restarts loading at zero
                r_load_count <= i_last_bit ? '0 : r_load_count + t_addr'(1);
            end
        end
    end

    ptms_ram #(
        .WIDTH (1),
        .DEPTH (STORE_DEPTH)
    ) u_cube (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_load_count),
        .i_wdata (i_cube_bit),
        .i_re    (rd.en),
        .i_raddr (rd.addr),
        .o_rdata (rd_data)
    );

    ptms_walker #(
        .MAX_SIZE (MAX_SIZE)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept && i_last_bit),
        .i_size_m1 (size_m1),
        .o_rd      (rd),
        .i_rd_data (rd_data),
        .o_sts     (sts)
    );

`include "perfect_triple_matching_search_assert.svh"

    `PTMS_ASSERT_NEXT(a_last_starts_search, i_clk, i_rst_n, accept && i_last_bit, busy)
    `PTMS_ASSERT_NOW(a_done_after_walk, i_clk, i_rst_n, o_done, $past(busy))
    `PTMS_ASSERT_NOW(a_done_load_cleared, i_clk, i_rst_n, o_done, r_load_count == '0)

endmodule

`default_nettype wire
